### hdl/lcc_pkg.sv
// shared types and constants of the line crossing counter
`default_nettype none

package lcc_pkg;

  localparam int COORD_W         = 32;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int ORI_W           = PROD_W + 1;
  localparam int CNT_W           = 11;
  localparam int SUM_W           = 48;
  localparam int PED_IDX_W       = 10;
  localparam int IDX_CMP_W       = 17;
  localparam int MAX_OBJECTS_DEF = 1024;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = COORD_W;
  localparam int IN_DATA_W       = 176;
  localparam int IN_USER_W       = 2;
  localparam int OUT_DATA_W      = 64;
  localparam int IN_PAD_W        = IN_DATA_W - PED_IDX_W - 5 * COORD_W;
  localparam int OUT_PAD_W       = OUT_DATA_W - 1 - CNT_W - SUM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } lcc_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } lcc_pt_t;

  // sign of one orientation determinant
  typedef struct packed {
    logic neg;
    logic zero;
  } lcc_ori_t;

  // request payload, lowest field in the lowest bits
  typedef struct packed {
    logic [IN_PAD_W-1:0]       pad;
    logic signed [COORD_W-1:0] speed;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] prev_x;
    logic [PED_IDX_W-1:0]      ped_index;
  } lcc_in_data_t;

  // lowest field in the lowest bit
  typedef struct packed {
    logic has_previous;
    logic op;
  } lcc_in_user_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]    pad;
    logic signed [SUM_W-1:0] total_speed;
    logic [CNT_W-1:0]        total_crossings;
    logic                    crossed_now;
  } lcc_out_data_t;

  // per stage control of one request
  typedef struct packed {
    logic                      op;
    logic                      has_prev;
    logic                      in_range;
    logic                      seen;
    logic signed [COORD_W-1:0] speed;
  } lcc_ctl_t;

endpackage

`default_nettype wire

### hdl/lcc_seg_test.sv
// three stage segment intersection test on exact integer geometry
`default_nettype none

module lcc_seg_test (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire lcc_pkg::lcc_pt_t line_a_i,
  input  wire lcc_pkg::lcc_pt_t line_b_i,
  input  wire lcc_pkg::lcc_pt_t mot_c_i,
  input  wire lcc_pkg::lcc_pt_t mot_d_i,
  output logic                 meet_o
);
  import lcc_pkg::*;

  function automatic logic signed [DIFF_W-1:0] dsub(logic signed [COORD_W-1:0] p,
                                                    logic signed [COORD_W-1:0] q);
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  function automatic logic in_box(lcc_pt_t p, lcc_pt_t q, lcc_pt_t r);
    logic bx, by;
    bx = (r.x >= p.x && r.x <= q.x) || (r.x >= q.x && r.x <= p.x);
    by = (r.y >= p.y && r.y <= q.y) || (r.y >= q.y && r.y <= p.y);
    return bx && by;
  endfunction

  function automatic lcc_ori_t ori(logic signed [PROD_W-1:0] p1,
                                   logic signed [PROD_W-1:0] p2);
    logic signed [ORI_W-1:0] v;
    lcc_ori_t o;
    v      = ORI_W'(p1) - ORI_W'(p2);
    o.neg  = v[ORI_W-1];
    o.zero = (v == '0);
    return o;
  endfunction

  // stage 1: coordinate differences
  logic signed [DIFF_W-1:0] bax_q, bay_q, cax_q, cay_q, dax_q, day_q;
  logic signed [DIFF_W-1:0] dcx_q, dcy_q, acx_q, acy_q, bcx_q, bcy_q;
  lcc_pt_t a_q, b_q, c_q, d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bax_q <= dsub(line_b_i.x, line_a_i.x);
      bay_q <= dsub(line_b_i.y, line_a_i.y);
      cax_q <= dsub(mot_c_i.x, line_a_i.x);
      cay_q <= dsub(mot_c_i.y, line_a_i.y);
      dax_q <= dsub(mot_d_i.x, line_a_i.x);
      day_q <= dsub(mot_d_i.y, line_a_i.y);
      dcx_q <= dsub(mot_d_i.x, mot_c_i.x);
      dcy_q <= dsub(mot_d_i.y, mot_c_i.y);
      acx_q <= dsub(line_a_i.x, mot_c_i.x);
      acy_q <= dsub(line_a_i.y, mot_c_i.y);
      bcx_q <= dsub(line_b_i.x, mot_c_i.x);
      bcy_q <= dsub(line_b_i.y, mot_c_i.y);
      a_q   <= line_a_i;
      b_q   <= line_b_i;
      c_q   <= mot_c_i;
      d_q   <= mot_d_i;
    end
  end

  // stage 2: cross products and bounding boxes
  logic signed [PROD_W-1:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, p4a_q, p4b_q;
  logic [3:0] box2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1a_q  <= bax_q * cay_q;
      p1b_q  <= bay_q * cax_q;
      p2a_q  <= bax_q * day_q;
      p2b_q  <= bay_q * dax_q;
      p3a_q  <= dcx_q * acy_q;
      p3b_q  <= dcy_q * acx_q;
      p4a_q  <= dcx_q * bcy_q;
      p4b_q  <= dcy_q * bcx_q;
      box2_q <= {in_box(c_q, d_q, b_q), in_box(c_q, d_q, a_q),
                 in_box(a_q, b_q, d_q), in_box(a_q, b_q, c_q)};
    end
  end

  // stage 3: orientation signs
  lcc_ori_t o1_q, o2_q, o3_q, o4_q;
  logic [3:0] box3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o1_q   <= ori(p1a_q, p1b_q);
      o2_q   <= ori(p2a_q, p2b_q);
      o3_q   <= ori(p3a_q, p3b_q);
      o4_q   <= ori(p4a_q, p4b_q);
      box3_q <= box2_q;
    end
  end

  always_comb begin
    meet_o = ((o1_q != o2_q) && (o3_q != o4_q))
          || (o1_q.zero && box3_q[0])
          || (o2_q.zero && box3_q[1])
          || (o3_q.zero && box3_q[2])
          || (o4_q.zero && box3_q[3]);
  end

endmodule

`default_nettype wire

### hdl/line_crossing_counter.sv
// top level of the line crossing counter
//
// requests enter on the s_axis channel: tuser says whether it is an object
// sample or an end of frame request, tdata carries index, positions, speed.
// each request gives exactly one result on m_axis with the totals after it.
// the reference line is set through the write port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// one request per cycle is taken unless stalled; each passes the three geometry
// stages (differences, products, orientation signs) ahead of the commit.
// per object flags sit in a one port-pair synchronous memory, read when the
// request is taken and written at commit; hits of requests still in flight
// are forwarded along the stages so an object is never counted twice.
// after reset a clearing pass writes every flag entry, one a cycle, and
// s_axis_tready stays low until the pass ends.
// when m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready falls.
`default_nettype none

module line_crossing_counter #(
  parameter int MAX_OBJECTS = lcc_pkg::MAX_OBJECTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // ped_index, prev_x, prev_y, cur_x, cur_y, speed, zero pad
  input  wire logic [lcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op, has_previous
  input  wire logic [lcc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // crossed_now, total_crossings, total_speed, zero pad
  output logic [lcc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // frame_summary
  output logic                                m_axis_tuser,
  input  wire logic                           cfg_we_i,
  input  wire logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lcc_pkg::*;

  localparam int AW = $clog2(MAX_OBJECTS);

  lcc_in_data_t in_data;
  lcc_in_user_t in_user;
  assign in_data = lcc_in_data_t'(s_axis_tdata);
  assign in_user = lcc_in_user_t'(s_axis_tuser);

  // line registers
  lcc_pt_t line_a_q, line_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_a_q <= '0;
      line_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lcc_reg_e'(cfg_idx_i))
        REG_START_X: line_a_q.x <= cfg_data_i;
        REG_START_Y: line_a_q.y <= cfg_data_i;
        REG_END_X:   line_b_q.x <= cfg_data_i;
        REG_END_Y:   line_b_q.y <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // pipeline control
  logic en, accept;
  logic clr_busy_q;
  logic [AW-1:0] clr_q;
  logic m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en && !clr_busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [IDX_CMP_W-1:0] ped_ext;
  logic [AW-1:0]        in_addr;
  assign ped_ext = {{(IDX_CMP_W - PED_IDX_W){1'b0}}, in_data.ped_index};
  assign in_addr = ped_ext[AW-1:0];

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  lcc_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  lcc_ctl_t s2_ctl_d, s3_ctl_d;
  logic [AW-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
  logic rd_flag_q;
  logic meet;
  logic hit;
  lcc_pt_t mot_c, mot_d;

  assign hit = s3_valid_q && !s3_ctl_q.op && s3_ctl_q.has_prev && s3_ctl_q.in_range
            && !s3_ctl_q.seen && meet;

  assign mot_c = {in_data.prev_x, in_data.prev_y};
  assign mot_d = {in_data.cur_x, in_data.cur_y};

  lcc_seg_test u_seg (
    .clk_i    (clk_i),
    .en_i     (en),
    .line_a_i (line_a_q),
    .line_b_i (line_b_q),
    .mot_c_i  (mot_c),
    .mot_d_i  (mot_d),
    .meet_o   (meet)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_comb begin
    s2_ctl_d      = s1_ctl_q;
    s2_ctl_d.seen = s1_ctl_q.seen || rd_flag_q || (hit && (s3_idx_q == s1_idx_q));
    s3_ctl_d      = s2_ctl_q;
    s3_ctl_d.seen = s2_ctl_q.seen || (hit && (s3_idx_q == s2_idx_q));
  end

  // forwarding of commits that the flag read cannot see yet
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ctl_q.op       <= in_user.op;
      s1_ctl_q.has_prev <= in_user.has_previous;
      s1_ctl_q.in_range <= ped_ext < IDX_CMP_W'(MAX_OBJECTS);
      s1_ctl_q.speed    <= in_data.speed;
      s1_ctl_q.seen     <= hit && (s3_idx_q == in_addr);
      s1_idx_q          <= in_addr;
      s2_ctl_q          <= s2_ctl_d;
      s2_idx_q          <= s1_idx_q;
      s3_ctl_q          <= s3_ctl_d;
      s3_idx_q          <= s2_idx_q;
    end
  end

  // flag memory with clearing pass
  logic flag_mem [MAX_OBJECTS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;

  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = 1'b0;
    end else begin
      mem_we    = en && hit;
      mem_waddr = s3_idx_q;
      mem_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flag_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_flag_q <= flag_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else if (clr_busy_q) begin
      if (clr_q == AW'(MAX_OBJECTS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // totals
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W:0]   sum_ext;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sum_ext = {sum_q[SUM_W-1], sum_q} + (SUM_W + 1)'(s3_ctl_q.speed);
    if (hit) begin
      if (count_q != '1) begin
        count_d = count_q + 1'b1;
      end
      priority if (sum_ext[SUM_W] == sum_ext[SUM_W-1]) begin
        sum_d = sum_ext[SUM_W-1:0];
      end else if (sum_ext[SUM_W]) begin
        sum_d = {1'b1, {(SUM_W - 1){1'b0}}};
      end else begin
        sum_d = {1'b0, {(SUM_W - 1){1'b1}}};
      end
    end
  end

  lcc_out_data_t out_q;
  logic          out_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      count_q   <= count_d;
      sum_q     <= sum_d;
      m_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_valid_q) begin
      out_q.pad             <= '0;
      out_q.crossed_now     <= hit;
      out_q.total_crossings <= count_d;
      out_q.total_speed     <= sum_d;
      out_frame_q           <= s3_ctl_q.op;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);
  assign m_axis_tuser  = out_frame_q;

  // checks
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("request taken during flag clearing");

  a_no_commit_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s3_valid_q)
    else $error("commit overlaps flag clearing");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q))
    else $error("crossing count went down");

  a_summary_no_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_frame_q |-> !out_q.crossed_now)
    else $error("frame summary flagged as crossing");

endmodule

`default_nettype wire

### bench/tb_line_crossing_counter.sv
// self-checking testbench of the line crossing counter with its own crossing predictor
`default_nettype none

module tb_line_crossing_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import lcc_pkg::*;

  localparam bit OP_SAMPLE    = 1'b0;
  localparam bit OP_FRAME_END = 1'b1;
  localparam int ONE          = 65536;
  localparam int INT_MAX      = 32'sh7fffffff;
  localparam int INT_MIN      = 32'sh80000000;
  localparam longint SPEED_HI = 64'sd140737488355327;
  localparam longint SPEED_LO = -64'sd140737488355328;
  localparam logic [CNT_W-1:0] COUNT_TOP = '1;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic             crossed;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] speed;
    logic             summary;
  } tally_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  lcc_in_data_t          req_data;
  lcc_in_user_t          req_user;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor state
  logic [MAX_OBJECTS_DEF-1:0] crossed_marks;
  logic [CNT_W-1:0]           crossing_total;
  longint                     speed_total;
  lcc_pt_t                    line_a;
  lcc_pt_t                    line_b;

  tally_t tally_q[$];
  int     n_fail;
  int     idle_cycles;
  bit     idle_on;

  line_crossing_counter u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (req_data),
    .s_axis_tuser  (req_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk = ~clk;

  function automatic int orient_of(lcc_pt_t p, lcc_pt_t q, lcc_pt_t r);
    logic signed [67:0] ux, uy, vx, vy, det;
    ux  = q.x - p.x;
    uy  = q.y - p.y;
    vx  = r.x - p.x;
    vy  = r.y - p.y;
    det = ux * vy - uy * vx;
    if (det > 0) return 1;
    if (det < 0) return -1;
    return 0;
  endfunction

  function automatic bit on_box(lcc_pt_t p, lcc_pt_t q, lcc_pt_t r);
    logic signed [COORD_W-1:0] lx, hx, ly, hy;
    lx = (p.x < q.x) ? p.x : q.x;
    hx = (p.x < q.x) ? q.x : p.x;
    ly = (p.y < q.y) ? p.y : q.y;
    hy = (p.y < q.y) ? q.y : p.y;
    return r.x >= lx && r.x <= hx && r.y >= ly && r.y <= hy;
  endfunction

  function automatic bit segments_meet(lcc_pt_t a, lcc_pt_t b, lcc_pt_t c, lcc_pt_t d);
    int o1, o2, o3, o4;
    o1 = orient_of(a, b, c);
    o2 = orient_of(a, b, d);
    o3 = orient_of(c, d, a);
    o4 = orient_of(c, d, b);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == 0 && on_box(a, b, c)) return 1'b1;
    if (o2 == 0 && on_box(a, b, d)) return 1'b1;
    if (o3 == 0 && on_box(c, d, a)) return 1'b1;
    if (o4 == 0 && on_box(c, d, b)) return 1'b1;
    return 1'b0;
  endfunction

  // updates the crossing state for one request and returns the totals after it
  function automatic tally_t apply_request(lcc_in_user_t u, lcc_in_data_t d);
    tally_t  t;
    lcc_pt_t c, e;
    longint  s;
    t.crossed = 1'b0;
    c.x = d.prev_x;
    c.y = d.prev_y;
    e.x = d.cur_x;
    e.y = d.cur_y;
    if (u.op == OP_SAMPLE && u.has_previous && int'(d.ped_index) < MAX_OBJECTS_DEF &&
        !crossed_marks[d.ped_index] && segments_meet(line_a, line_b, c, e)) begin
      crossed_marks[d.ped_index] = 1'b1;
      if (crossing_total != COUNT_TOP) crossing_total++;
      s = speed_total + longint'(d.speed);
      if (s > SPEED_HI) s = SPEED_HI;
      if (s < SPEED_LO) s = SPEED_LO;
      speed_total = s;
      t.crossed = 1'b1;
    end
    t.count   = crossing_total;
    t.speed   = speed_total[SUM_W-1:0];
    t.summary = u.op;
    return t;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp32(longint v);
    if (v > longint'(INT_MAX)) return INT_MAX;
    if (v < longint'(INT_MIN)) return INT_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_between(longint lo, longint hi);
    longint unsigned r, span;
    if (lo < longint'(INT_MIN)) lo = INT_MIN;
    if (hi > longint'(INT_MAX)) hi = INT_MAX;
    r    = {$urandom, $urandom};
    span = hi - lo + 1;
    return clamp32(lo + longint'(r % span));
  endfunction

  task automatic send_req(input bit op, input bit hp, input logic [PED_IDX_W-1:0] idx,
                          input int px, input int py, input int cx, input int cy,
                          input int spd);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_user.op           <= op;
    req_user.has_previous <= hp;
    req_data.pad          <= '0;
    req_data.ped_index    <= idx;
    req_data.prev_x       <= px;
    req_data.prev_y       <= py;
    req_data.cur_x        <= cx;
    req_data.cur_y        <= cy;
    req_data.speed        <= spd;
    s_axis_tvalid         <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    tally_q.insert(tally_q.size(), apply_request(req_user, req_data));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input lcc_reg_e r, input int v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    case (r)
      REG_START_X: line_a.x = v;
      REG_START_Y: line_a.y = v;
      REG_END_X:   line_b.x = v;
      REG_END_Y:   line_b.y = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_line(input int ax, input int ay, input int bx, input int by);
    wait_drained();
    write_reg(REG_START_X, ax);
    write_reg(REG_START_Y, ay);
    write_reg(REG_END_X, bx);
    write_reg(REG_END_Y, by);
    cfg_we_i <= 1'b0;
    @(negedge clk);
  endtask

  // motion around the current line: crossings, touches, collinear runs, points
  task automatic random_item();
    logic signed [COORD_W-1:0] px, py, cx, cy;
    longint lx, hx, ly, hy, mx, my, dx, dy;
    int     kind;
    bit     op, hp;
    op   = ($urandom_range(0, 99) < 8);
    hp   = ($urandom_range(0, 9) != 0);
    dx   = longint'(line_b.x) - longint'(line_a.x);
    dy   = longint'(line_b.y) - longint'(line_a.y);
    lx   = (dx < 0) ? longint'(line_b.x) : longint'(line_a.x);
    ly   = (dy < 0) ? longint'(line_b.y) : longint'(line_a.y);
    hx   = lx + ((dx < 0) ? -dx : dx);
    hy   = ly + ((dy < 0) ? -dy : dy);
    mx   = (hx - lx) / 4 + 4;
    my   = (hy - ly) / 4 + 4;
    px   = pick_between(lx - mx, hx + mx);
    py   = pick_between(ly - my, hy + my);
    cx   = pick_between(lx - mx, hx + mx);
    cy   = pick_between(ly - my, hy + my);
    kind = $urandom_range(0, 9);
    case (kind)
      6: begin
        if ($urandom_range(0, 1)) begin
          cx = line_a.x;
          cy = line_a.y;
        end else begin
          cx = line_b.x;
          cy = line_b.y;
        end
      end
      7: begin
        px = clamp32(longint'(line_a.x) + dx * longint'($urandom_range(0, 16)) / 8 - dx / 2);
        py = clamp32(longint'(line_a.y) + dy * longint'($urandom_range(0, 16)) / 8 - dy / 2);
        cx = clamp32(longint'(line_a.x) + dx * longint'($urandom_range(0, 16)) / 8 - dx / 2);
        cy = clamp32(longint'(line_a.y) + dy * longint'($urandom_range(0, 16)) / 8 - dy / 2);
      end
      8: begin
        cx = px;
        cy = py;
      end
      9: begin
        px = $urandom;
        py = $urandom;
        cx = $urandom;
        cy = $urandom;
      end
      default: ;
    endcase
    send_req(op, hp, PED_IDX_W'($urandom_range(0, MAX_OBJECTS_DEF - 1)), px, py, cx, cy,
             $urandom);
  endtask

  // line left at its reset value, a single point at the origin
  task automatic test_reset_line();
    send_req(OP_FRAME_END, 1'b1, 10'd5, -ONE, -ONE, ONE, ONE, $urandom);
    send_req(OP_SAMPLE, 1'b1, 10'd0, -1, -1, 1, 1, INT_MAX);
    send_req(OP_SAMPLE, 1'b1, 10'd0, -1, -1, 1, 1, INT_MAX);
    send_req(OP_SAMPLE, 1'b0, 10'd1, -1, 1, 1, -1, 77);
    send_req(OP_SAMPLE, 1'b1, 10'd1, ONE, 0, 2 * ONE, 0, 77);
    send_req(OP_SAMPLE, 1'b1, 10'd2, 0, 0, 0, 0, INT_MIN);
    send_req(OP_SAMPLE, 1'b1, 10'd3, INT_MIN, INT_MIN, INT_MAX, INT_MAX, $urandom);
    send_req(OP_FRAME_END, 1'b0, 10'd0, 0, 0, 0, 0, 0);
  endtask

  // horizontal line of twenty metres through the origin
  task automatic test_geometry_cases();
    set_line(-10 * ONE, 0, 10 * ONE, 0);
    send_req(OP_SAMPLE, 1'b1, 10'd10, 0, -ONE, 0, ONE, 3 * ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd11, 10 * ONE, 5 * ONE, 10 * ONE, 0, ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd12, 5 * ONE, 0, 20 * ONE, 0, -ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd13, 11 * ONE, 0, 20 * ONE, 0, ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd14, -5 * ONE, ONE, 5 * ONE, ONE, ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd15, 3 * ONE, 0, 3 * ONE, 0, ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd16, 3 * ONE, 1, 3 * ONE, 1, ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd1023, INT_MIN, INT_MIN, INT_MAX, INT_MAX, INT_MAX);
    send_req(OP_SAMPLE, 1'b1, 10'd17, 10 * ONE + 1, -1, 10 * ONE + 1, 1, ONE);
    send_req(OP_FRAME_END, 1'b1, 10'd20, 0, -ONE, 0, ONE, ONE);
    send_req(OP_SAMPLE, 1'b1, 10'd20, 0, -ONE, 0, ONE, -7 * ONE);
  endtask

  task automatic test_random_lines();
    set_line(-3 * ONE, -2 * ONE, 5 * ONE, 7 * ONE);
    repeat (150) random_item();
    wait_drained();
    repeat (150) random_item();
    set_line(INT_MIN, INT_MIN, INT_MAX, INT_MAX);
    repeat (280) random_item();
    set_line(1234, -100, 1234, 100);
    repeat (280) random_item();
    set_line(INT_MAX, INT_MIN, INT_MIN, INT_MAX);
    repeat (280) random_item();
  endtask

  task automatic test_steady_stream();
    set_line(-(1 << 20), 0, 1 << 20, 3);
    idle_on = 1'b0;
    repeat (290) random_item();
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    tally_t        want;
    lcc_out_data_t got;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (tally_q.size() == 0) begin
          $error("result with no request waiting");
          n_fail++;
        end else begin
          want = tally_q.pop_front();
          if (got.crossed_now !== want.crossed) begin
            $error("crossed_now: expected %0d, got %0d", want.crossed, got.crossed_now);
            n_fail++;
          end
          if (got.total_crossings !== want.count) begin
            $error("total_crossings: expected %0d, got %0d", want.count,
                   got.total_crossings);
            n_fail++;
          end
          if (got.total_speed !== want.speed) begin
            $error("total_speed: expected %0d, got %0d", $signed(want.speed),
                   got.total_speed);
            n_fail++;
          end
          if (m_axis_tuser !== want.summary) begin
            $error("frame_summary: expected %0d, got %0d", want.summary, m_axis_tuser);
            n_fail++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** line_crossing_counter: FAILED **");
        $finish;
      end
    end
  end

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    req_data       = '0;
    req_user       = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_START_X;
    cfg_data_i     = '0;
    crossed_marks  = '0;
    crossing_total = '0;
    speed_total    = 0;
    line_a         = '0;
    line_b         = '0;
    n_fail         = 0;
    idle_on        = 1'b1;
    repeat (5) @(negedge clk);
    rst_ni = 1'b1;
    test_reset_line();
    test_geometry_cases();
    test_random_lines();
    test_steady_stream();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tally_q.size() != 0) begin
      $error("%0d results never arrived", tally_q.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("** line_crossing_counter: PASSED **");
    end else begin
      $display("** line_crossing_counter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
